>>> rtl/core/melody_tone_sequencer_defines.svh
// ---------------------------------------------------------------------------
// Melody tone sequencer assertion macros
// Concurrent property checks used by the sequencer RTL. They compile away
// when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MELODY_TONE_SEQUENCER_DEFINES_SVH
`define MELODY_TONE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define MTS_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("melody tone sequencer property failed");

// Consequent must hold in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("melody tone sequencer property failed");

`else

`define MTS_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define MTS_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

>>> rtl/core/mts_pkg.sv
// ---------------------------------------------------------------------------
// Melody tone sequencer package
// Shared types, command codes and widths for the sequencer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  // Default number of note table entries.
  localparam int TABLE_DEPTH_DEF = 64;

  // Width of melody lengths and note pointers.
  localparam int PTR_W = 7;

  // Saturation value of the pass counter and the endless repeat code.
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // Command codes carried in the input beat.
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_START  = 3'd2,
    OP_SINGLE = 3'd3,
    OP_STOP   = 3'd4,
    OP_MUTE   = 3'd5
  } op_t;

  // One note table entry.
  typedef struct packed {
    logic [7:0] pitch;
    logic [2:0] presc;
    logic [7:0] dur;
  } note_t;

  // One input item.
  typedef struct packed {
    logic [2:0]       op;
    logic [5:0]       entry_index;
    logic [7:0]       pitch_compare;
    logic [2:0]       prescaler_select;
    logic [7:0]       duration_ticks;
    logic [PTR_W-1:0] melody_length;
    logic [7:0]       repeat_count;
    logic             mute_value;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       tone_enable;
    logic [7:0] tone_pitch;
    logic [2:0] tone_prescaler;
    logic       playing;
    logic       muted;
    logic [7:0] passes_done;
  } res_t;

  // Request from the sequencer core to the note table.
  typedef struct packed {
    logic             en;
    logic             we;
    logic [PTR_W-1:0] waddr;
    note_t            wdata;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> rtl/core/mts_note_mem.sv
// ---------------------------------------------------------------------------
// Note table memory
// Single write port and one registered read port. The read fetches the
// entry that the sequencer will need when the current note ends; a write
// to that same entry in the same cycle is forwarded to the read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mts_note_mem #(
  parameter int TABLE_DEPTH = mts_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire mts_pkg::mem_req_t req,
  output mts_pkg::note_t        rd_note
);

  import mts_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  note_t note_mem [TABLE_DEPTH];
  note_t rd_note_r;

  // Write and prefetch read, both only when an item moves through.
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        note_mem[AW'(req.waddr)] <= req.wdata;
      end
      if (req.we && (req.waddr == req.raddr)) begin
        rd_note_r <= req.wdata;
      end else if (int'(req.raddr) < TABLE_DEPTH) begin
        rd_note_r <= note_mem[AW'(req.raddr)];
      end else begin
        rd_note_r <= '0;
      end
    end
  end

  assign rd_note = rd_note_r;

endmodule

`default_nettype wire

>>> rtl/core/mts_seq_core.sv
// ---------------------------------------------------------------------------
// Sequencer core
// Holds the sequencer state and works out, for the item in the input
// register, the next state, the note table request and the result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "melody_tone_sequencer_defines.svh"

module mts_seq_core #(
  parameter int TABLE_DEPTH = mts_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire mts_pkg::item_t    item,
  input  wire mts_pkg::note_t    pref_note,
  output mts_pkg::mem_req_t      mem_req,
  output mts_pkg::res_t          res
);

  import mts_pkg::*;

  logic [PTR_W-1:0] note_index_r, note_index_nxt;
  logic [7:0]       ticks_left_r, ticks_left_nxt;
  logic             active_r, active_nxt;
  logic             melody_r, melody_nxt;
  logic [PTR_W-1:0] length_r, length_nxt;
  logic [7:0]       repeats_r, repeats_nxt;
  logic [7:0]       pass_r, pass_nxt;
  logic             mute_r, mute_nxt;
  logic             tone_r, tone_nxt;
  logic [7:0]       pitch_r, pitch_nxt;
  logic [2:0]       presc_r, presc_nxt;
  note_t            entry0_r, entry0_nxt;

  logic             do_load;
  logic             do_stop;
  note_t            load_note;
  logic [PTR_W-1:0] next_ptr;
  logic [7:0]       pass_inc;
  logic             wr_ok;

  assign next_ptr = note_index_r + PTR_W'(1);
  assign pass_inc = (pass_r == COUNT_MAX) ? pass_r : pass_r + 8'd1;
  assign wr_ok    = int'(item.entry_index) < TABLE_DEPTH;

  // Next state for the item in the input register.
  always_comb begin
    note_index_nxt = note_index_r;
    ticks_left_nxt = ticks_left_r;
    active_nxt     = active_r;
    melody_nxt     = melody_r;
    length_nxt     = length_r;
    repeats_nxt    = repeats_r;
    pass_nxt       = pass_r;
    mute_nxt       = mute_r;
    tone_nxt       = tone_r;
    pitch_nxt      = pitch_r;
    presc_nxt      = presc_r;
    entry0_nxt     = entry0_r;
    do_load        = 1'b0;
    do_stop        = 1'b0;
    load_note      = pref_note;

    unique case (item.op)
      OP_TICK: begin
        if (active_r) begin
          if (ticks_left_r > 8'd1) begin
            ticks_left_nxt = ticks_left_r - 8'd1;
          end else if (!melody_r) begin
            do_stop = 1'b1;
          end else if (next_ptr >= length_r) begin
            // End of a pass: count it, then repeat or finish.
            pass_nxt = pass_inc;
            if ((repeats_r == COUNT_MAX) || (pass_inc < repeats_r)) begin
              note_index_nxt = '0;
              do_load        = 1'b1;
              load_note      = entry0_r;
            end else begin
              note_index_nxt = next_ptr;
              do_stop        = 1'b1;
            end
          end else begin
            note_index_nxt = next_ptr;
            do_load        = 1'b1;
            load_note      = pref_note;
          end
        end
      end
      OP_WRITE: begin
        if (wr_ok && (item.entry_index == '0)) begin
          entry0_nxt = '{pitch: item.pitch_compare, presc: item.prescaler_select,
                         dur: item.duration_ticks};
        end
      end
      OP_START: begin
        if (item.melody_length == '0) begin
          do_stop = 1'b1;
        end else begin
          length_nxt     = (int'(item.melody_length) > TABLE_DEPTH) ?
                           PTR_W'(TABLE_DEPTH) : item.melody_length;
          note_index_nxt = '0;
          repeats_nxt    = (item.repeat_count == '0) ? 8'd1 : item.repeat_count;
          pass_nxt       = '0;
          active_nxt     = 1'b1;
          melody_nxt     = 1'b1;
          do_load        = 1'b1;
          load_note      = entry0_r;
        end
      end
      OP_SINGLE: begin
        melody_nxt     = 1'b0;
        length_nxt     = '0;
        note_index_nxt = '0;
        repeats_nxt    = 8'd1;
        pass_nxt       = '0;
        active_nxt     = 1'b1;
        do_load        = 1'b1;
        load_note      = '{pitch: item.pitch_compare, presc: item.prescaler_select,
                           dur: item.duration_ticks};
      end
      OP_STOP: begin
        do_stop = 1'b1;
      end
      OP_MUTE: begin
        mute_nxt = item.mute_value;
        if (item.mute_value) begin
          tone_nxt  = 1'b0;
          presc_nxt = '0;
        end
      end
      default: begin
      end
    endcase

    // Start a note: a rest or mute leaves the tone generator off.
    if (do_load) begin
      ticks_left_nxt = (load_note.dur == '0) ? 8'd1 : load_note.dur;
      if ((load_note.pitch == '0) || (load_note.presc == '0) || mute_r) begin
        tone_nxt  = 1'b0;
        presc_nxt = '0;
      end else begin
        tone_nxt  = 1'b1;
        pitch_nxt = load_note.pitch;
        presc_nxt = load_note.presc;
      end
    end

    // Stop the sequencer and silence the tone.
    if (do_stop) begin
      active_nxt     = 1'b0;
      melody_nxt     = 1'b0;
      length_nxt     = '0;
      ticks_left_nxt = '0;
      tone_nxt       = 1'b0;
      presc_nxt      = '0;
    end
  end

  // Table request: write the entry, prefetch the entry after the new index.
  always_comb begin
    mem_req.en    = advance;
    mem_req.we    = (item.op == OP_WRITE) && wr_ok;
    mem_req.waddr = PTR_W'(item.entry_index);
    mem_req.wdata = '{pitch: item.pitch_compare, presc: item.prescaler_select,
                      dur: item.duration_ticks};
    mem_req.raddr = note_index_nxt + PTR_W'(1);
  end

  // Result shows the state after the item.
  always_comb begin
    res.tone_enable    = tone_nxt;
    res.tone_pitch     = pitch_nxt;
    res.tone_prescaler = presc_nxt;
    res.playing        = active_nxt;
    res.muted          = mute_nxt;
    res.passes_done    = pass_nxt;
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_index_r <= '0;
      ticks_left_r <= '0;
      active_r     <= 1'b0;
      melody_r     <= 1'b0;
      length_r     <= '0;
      repeats_r    <= 8'd1;
      pass_r       <= '0;
      mute_r       <= 1'b0;
      tone_r       <= 1'b0;
      pitch_r      <= '0;
      presc_r      <= '0;
    end else if (advance) begin
      note_index_r <= note_index_nxt;
      ticks_left_r <= ticks_left_nxt;
      active_r     <= active_nxt;
      melody_r     <= melody_nxt;
      length_r     <= length_nxt;
      repeats_r    <= repeats_nxt;
      pass_r       <= pass_nxt;
      mute_r       <= mute_nxt;
      tone_r       <= tone_nxt;
      pitch_r      <= pitch_nxt;
      presc_r      <= presc_nxt;
    end
  end

  // Shadow copy of entry zero, needed at melody start and on each repeat.
  always_ff @(posedge clk) begin
    if (advance) begin
      entry0_r <= entry0_nxt;
    end
  end

  // A sounding tone always belongs to an active sequence.
  `MTS_ASSERT_SAME(a_tone_needs_active, clk, rst_n, tone_r, active_r)
  // Mute never lets a tone sound.
  `MTS_ASSERT_SAME(a_mute_silences, clk, rst_n, mute_r, !tone_r)
  // A sounding tone has a non-zero prescaler and pitch.
  `MTS_ASSERT_SAME(a_tone_codes, clk, rst_n, tone_r, (presc_r != '0) && (pitch_r != '0))
  // A melody in progress has a length and its index stays inside it.
  `MTS_ASSERT_SAME(a_melody_bounds, clk, rst_n, melody_r,
                   (length_r != '0) && (note_index_r < length_r) && active_r)

endmodule

`default_nettype wire

>>> rtl/core/melody_tone_sequencer.sv
// ---------------------------------------------------------------------------
// Melody tone sequencer
// Tick-driven sequencer over a table of notes with pitch, prescaler and
// duration. Commands write the table, start a melody, play a single tone,
// stop or set mute; each beat returns the resulting tone state.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  in_       slave      in_tvalid/in_tready  tuser: op; tdata: command fields
//  out_      master     out_tvalid/tready    tdata: tone state after the item
//
//  One beat in, one beat out. An item waits in the input register and its
//  result sits in the output register; one item per cycle is sustained while
//  out_tready is high, set by the single-pass next-state logic and the note
//  table's registered prefetch read. Reset (rst_n low, synchronous) clears
//  the sequencer state; the note table is not cleared. A stalled output
//  holds its beat while the input register can still take one more item.
//
`default_nettype none
`include "melody_tone_sequencer_defines.svh"

module melody_tone_sequencer #(
  parameter int TABLE_DEPTH = mts_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata from bit 0: entry_index[5:0], pitch_compare[13:6],
  // prescaler_select[16:14], duration_ticks[24:17], melody_length[31:25],
  // repeat_count[39:32], mute_value[40], zero fill[47:41]
  input  wire logic [47:0] in_tdata,
  // tuser: op[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata from bit 0: tone_enable[0], tone_pitch[8:1], tone_prescaler[11:9],
  // playing[12], muted[13], passes_done[21:14], zero fill[23:22]
  output logic [23:0]      out_tdata
);

  import mts_pkg::*;

  logic     in_valid_r;
  item_t    in_item_r;
  logic     out_valid_r;
  res_t     out_res_r;
  logic     advance;
  res_t     res;
  mem_req_t mem_req;
  note_t    pref_note;

  // An item moves on when the output register is free or being emptied.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= '{op:               in_tuser,
                     entry_index:      in_tdata[5:0],
                     pitch_compare:    in_tdata[13:6],
                     prescaler_select: in_tdata[16:14],
                     duration_ticks:   in_tdata[24:17],
                     melody_length:    in_tdata[31:25],
                     repeat_count:     in_tdata[39:32],
                     mute_value:       in_tdata[40]};
    end
  end

  // Sequencer state and next-state logic.
  mts_seq_core #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (in_item_r),
    .pref_note (pref_note),
    .mem_req   (mem_req),
    .res       (res)
  );

  // Note table with prefetch read.
  mts_note_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_note (pref_note)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.passes_done, out_res_r.muted, out_res_r.playing,
                       out_res_r.tone_prescaler, out_res_r.tone_pitch,
                       out_res_r.tone_enable};

  // Every item that moves on produces a result beat in the next cycle.
  `MTS_ASSERT_NEXT(a_advance_gives_beat, clk, rst_n, advance, out_valid_r)
  // An item held back stays in the input register.
  `MTS_ASSERT_NEXT(a_held_item_kept, clk, rst_n, in_valid_r && !advance, in_valid_r)

endmodule

`default_nettype wire
